// ===== design/dtdc_pkg.sv =====
package dtdc_pkg;

  localparam int DISPARITY_FRAC_BITS = 5;

  localparam int DISP_W  = 17;
  localparam int DEN_W   = DISP_W - 1;
  localparam int DEPTH_W = 32;
  localparam int SCALE_W = 16;
  localparam int CODE_W  = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_W      = DEPTH_W + DISPARITY_FRAC_BITS + 1;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W      = DIV_STAGES * DIV_STEPS;

  localparam int PROD_W    = DEPTH_W + SCALE_W;
  localparam int RND_SHIFT = 16;
  localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (RND_SHIFT - 1);

  localparam logic [DEPTH_W-1:0] FOCAL_BASELINE_RST = DEPTH_W'(3276800);
  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST      = DEPTH_W'(6554);
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST      = DEPTH_W'(6553600);
  localparam logic [SCALE_W-1:0] CODE_SCALE_RST     = SCALE_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_BASELINE = 2'd0,
    CFG_MIN_DEPTH      = 2'd1,
    CFG_MAX_DEPTH      = 2'd2,
    CFG_CODE_SCALE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic             vld;
    logic             pos;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] num;
  } div_t;

  typedef struct packed {
    logic               vld;
    logic [DEPTH_W-1:0] meters;
    logic [CODE_W-1:0]  code;
    logic               dvalid;
  } res_t;

endpackage

// ===== design/dtdc_prep.sv =====
module dtdc_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                in_valid_i,
  input  logic signed [dtdc_pkg::DISP_W-1:0]  disparity_i,
  input  logic                                disparity_finite_i,
  input  logic [dtdc_pkg::DEPTH_W-1:0]        focal_baseline_i,
  output dtdc_pkg::div_t                      stage_o
);

  dtdc_pkg::div_t stage_d, stage_q;

  always_comb begin
    stage_d.vld = in_valid_i;
    stage_d.pos = disparity_finite_i && !disparity_i[dtdc_pkg::DISP_W-1] &&
                  (disparity_i != '0);
    stage_d.den = disparity_i[dtdc_pkg::DEN_W-1:0];
    stage_d.rem = '0;
    stage_d.num = (dtdc_pkg::DIV_W'(focal_baseline_i) << dtdc_pkg::DISPARITY_FRAC_BITS) +
                  dtdc_pkg::DIV_W'(disparity_i[dtdc_pkg::DEN_W-1:1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== design/dtdc_div_stage.sv =====
module dtdc_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  dtdc_pkg::div_t stage_i,
  output dtdc_pkg::div_t stage_o
);

  dtdc_pkg::div_t stage_d, stage_q;

  always_comb begin
    logic [dtdc_pkg::DEN_W+1:0] diff;
    logic                       ge;
    logic [dtdc_pkg::DEN_W-1:0] rem;
    logic [dtdc_pkg::DIV_W-1:0] num;
    rem = stage_i.rem;
    num = stage_i.num;
    for (int i = 0; i < dtdc_pkg::DIV_STEPS; i++) begin
      diff = {1'b0, rem, num[dtdc_pkg::DIV_W-1]} - {2'b00, stage_i.den};
      ge   = !diff[dtdc_pkg::DEN_W+1];
      rem  = ge ? diff[dtdc_pkg::DEN_W-1:0] : {rem[dtdc_pkg::DEN_W-2:0], num[dtdc_pkg::DIV_W-1]};
      num  = {num[dtdc_pkg::DIV_W-2:0], ge};
    end
    stage_d     = stage_i;
    stage_d.rem = rem;
    stage_d.num = num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== design/dtdc_post.sv =====
module dtdc_post (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  dtdc_pkg::div_t                stage_i,
  input  logic [dtdc_pkg::DEPTH_W-1:0]  min_depth_i,
  input  logic [dtdc_pkg::DEPTH_W-1:0]  max_depth_i,
  input  logic [dtdc_pkg::SCALE_W-1:0]  code_scale_i,
  output dtdc_pkg::res_t                res_o
);

  logic                          sat;
  logic [dtdc_pkg::DEPTH_W-1:0]  a_depth_d;
  logic                          a_ok_d;
  logic [dtdc_pkg::PROD_W:0]     rnd;
  logic [dtdc_pkg::CODE_W-1:0]   code;

  logic                          a_vld_q, a_ok_q;
  logic [dtdc_pkg::DEPTH_W-1:0]  a_depth_q;
  logic                          b_vld_q, b_ok_q;
  logic [dtdc_pkg::DEPTH_W-1:0]  b_depth_q;
  logic [dtdc_pkg::PROD_W-1:0]   b_prod_q;
  dtdc_pkg::res_t                res_d, res_q;

  assign sat       = |stage_i.num[dtdc_pkg::DIV_W-1:dtdc_pkg::DEPTH_W];
  assign a_depth_d = sat ? '1 : stage_i.num[dtdc_pkg::DEPTH_W-1:0];
  assign a_ok_d    = stage_i.pos && (a_depth_d >= min_depth_i) && (a_depth_d <= max_depth_i);

  assign rnd  = {1'b0, b_prod_q} + dtdc_pkg::RND_HALF;
  assign code = (|rnd[dtdc_pkg::PROD_W:dtdc_pkg::RND_SHIFT+dtdc_pkg::CODE_W]) ? '1 :
                rnd[dtdc_pkg::RND_SHIFT+dtdc_pkg::CODE_W-1:dtdc_pkg::RND_SHIFT];

  always_comb begin
    res_d.vld    = b_vld_q;
    res_d.dvalid = b_ok_q;
    res_d.meters = b_ok_q ? b_depth_q : '0;
    res_d.code   = b_ok_q ? code : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      a_ok_q    <= 1'b0;
      a_depth_q <= '0;
      b_vld_q   <= 1'b0;
      b_ok_q    <= 1'b0;
      b_depth_q <= '0;
      b_prod_q  <= '0;
      res_q     <= '0;
    end else if (en_i) begin
      a_vld_q   <= stage_i.vld;
      a_ok_q    <= a_ok_d;
      a_depth_q <= a_depth_d;
      b_vld_q   <= a_vld_q;
      b_ok_q    <= a_ok_q;
      b_depth_q <= a_depth_q;
      b_prod_q  <= dtdc_pkg::PROD_W'(a_depth_q) * dtdc_pkg::PROD_W'(code_scale_i);
      res_q     <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/dtdc_obuf.sv =====
module dtdc_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtdc_pkg::res_t res_i,
  input  logic           out_stall_i,
  output dtdc_pkg::res_t out_o,
  output logic           en_o
);

  dtdc_pkg::res_t out_q, skid_q;
  logic           push, pop;

  assign en_o = !skid_q.vld;
  assign push = en_o && res_i.vld;
  assign pop  = out_q.vld && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else if (skid_q.vld) begin
      if (pop) begin
        out_q  <= skid_q;
        skid_q <= '0;
      end
    end else if (push) begin
      if (!out_q.vld || pop) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end else if (pop) begin
      out_q <= '0;
    end
  end

  assign out_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_q.vld |-> out_q.vld)
    else $error("skid word held with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q.vld && !pop) |=> (skid_q.vld && $stable(skid_q)))
    else $error("skid word lost while output stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q.vld && out_stall_i) |=> (out_q.vld && $stable(out_q)))
    else $error("stalled output word changed");

endmodule

// ===== design/disparity_to_depth_code.sv =====
// Converts one disparity pixel per clock, while in_stall_o is low, into Q16.16
// depth and a 16-bit scaled depth code; throughput is one pixel every cycle
// unless stalled. An accepted pixel passes the input register, the radix-4
// divider pipeline (DIV_STAGES stages, two quotient bits each), and the range
// check, multiply, rounding and output registers to its result word. A two-word
// output buffer takes back-pressure; in_stall_o rises only once it is full.
// Configuration registers must be written while no pixel is in flight.
module disparity_to_depth_code (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [dtdc_pkg::DISP_W-1:0]   disparity_i,
  input  logic                                 disparity_finite_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dtdc_pkg::DEPTH_W-1:0]         depth_m_o,
  output logic [dtdc_pkg::CODE_W-1:0]          depth_code_o,
  output logic                                 depth_valid_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dtdc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dtdc_pkg::CFG_W-1:0]           cfg_data_i
);

  logic [dtdc_pkg::DEPTH_W-1:0] focal_baseline_q, min_depth_q, max_depth_q;
  logic [dtdc_pkg::SCALE_W-1:0] code_scale_q;
  logic                         en;
  dtdc_pkg::div_t               div_s [dtdc_pkg::DIV_STAGES+1];
  dtdc_pkg::res_t               res, out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_baseline_q <= dtdc_pkg::FOCAL_BASELINE_RST;
      min_depth_q      <= dtdc_pkg::MIN_DEPTH_RST;
      max_depth_q      <= dtdc_pkg::MAX_DEPTH_RST;
      code_scale_q     <= dtdc_pkg::CODE_SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dtdc_pkg::cfg_idx_e'(cfg_index_i))
        dtdc_pkg::CFG_FOCAL_BASELINE: focal_baseline_q <= cfg_data_i;
        dtdc_pkg::CFG_MIN_DEPTH:      min_depth_q      <= cfg_data_i;
        dtdc_pkg::CFG_MAX_DEPTH:      max_depth_q      <= cfg_data_i;
        dtdc_pkg::CFG_CODE_SCALE:     code_scale_q     <= cfg_data_i[dtdc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !en;

  dtdc_prep u_prep (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .in_valid_i         (in_valid_i),
    .disparity_i        (disparity_i),
    .disparity_finite_i (disparity_finite_i),
    .focal_baseline_i   (focal_baseline_q),
    .stage_o            (div_s[0])
  );

  for (genvar g = 0; g < dtdc_pkg::DIV_STAGES; g++) begin : g_div
    dtdc_div_stage u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (div_s[g]),
      .stage_o (div_s[g+1])
    );
  end

  dtdc_post u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .stage_i       (div_s[dtdc_pkg::DIV_STAGES]),
    .min_depth_i   (min_depth_q),
    .max_depth_i   (max_depth_q),
    .code_scale_i  (code_scale_q),
    .res_o         (res)
  );

  dtdc_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_o       (out),
    .en_o        (en)
  );

  assign out_valid_o    = out.vld;
  assign depth_m_o      = out.meters;
  assign depth_code_o   = out.code;
  assign depth_valid_o  = out.dvalid;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_valid_o) |->
    (depth_m_o >= min_depth_q && depth_m_o <= max_depth_q))
    else $error("accepted depth outside configured range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !depth_valid_o) |-> (depth_m_o == '0 && depth_code_o == '0))
    else $error("rejected pixel carries nonzero depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_valid_o && depth_m_o == '0) |-> (depth_code_o == '0))
    else $error("zero depth with nonzero code");

endmodule

// ===== test/disparity_to_depth_code_test.sv =====
`timescale 1ns / 100ps

module disparity_to_depth_code_test;

  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic signed [dtdc_pkg::DISP_W-1:0] disp;
    logic                               fin;
  } pixel_t;

  typedef struct packed {
    logic [dtdc_pkg::DEPTH_W-1:0] meters;
    logic [dtdc_pkg::CODE_W-1:0]  code;
    logic                         valid;
  } depth_word_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic signed [dtdc_pkg::DISP_W-1:0]   disparity_i = '0;
  logic                                 disparity_finite_i = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic [dtdc_pkg::DEPTH_W-1:0]         depth_m_o;
  logic [dtdc_pkg::CODE_W-1:0]          depth_code_o;
  logic                                 depth_valid_o;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [dtdc_pkg::CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [dtdc_pkg::CFG_W-1:0]           cfg_data_i = '0;

  logic [dtdc_pkg::DEPTH_W-1:0] focal_baseline = dtdc_pkg::FOCAL_BASELINE_RST;
  logic [dtdc_pkg::DEPTH_W-1:0] min_depth = dtdc_pkg::MIN_DEPTH_RST;
  logic [dtdc_pkg::DEPTH_W-1:0] max_depth = dtdc_pkg::MAX_DEPTH_RST;
  logic [dtdc_pkg::SCALE_W-1:0] code_scale = dtdc_pkg::CODE_SCALE_RST;

  pixel_t      pixel_backlog[$];
  depth_word_t pending_depths[$];
  depth_word_t rx_word;
  pixel_t      tx_pixel;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          tx_wait = 0;
  int          rx_wait = 0;
  int          errors = 0;
  int          idle_cycles = 0;

  disparity_to_depth_code uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .disparity_i        (disparity_i),
    .disparity_finite_i (disparity_finite_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .depth_m_o          (depth_m_o),
    .depth_code_o       (depth_code_o),
    .depth_valid_o      (depth_valid_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic depth_word_t convert_pixel(logic signed [dtdc_pkg::DISP_W-1:0] disp,
                                                logic fin);
    depth_word_t w;
    logic [63:0] den;
    logic [63:0] quot;
    logic [63:0] code_full;
    w = '0;
    if (fin && !disp[dtdc_pkg::DISP_W-1] && disp != 0) begin
      den = {48'd0, disp[dtdc_pkg::DISP_W-2:0]};
      quot = (({32'd0, focal_baseline} << dtdc_pkg::DISPARITY_FRAC_BITS) + (den >> 1)) / den;
      if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
      if (quot >= {32'd0, min_depth} && quot <= {32'd0, max_depth}) begin
        code_full = (quot * {48'd0, code_scale} + 64'h8000) >> dtdc_pkg::RND_SHIFT;
        if (code_full > 64'hFFFF) code_full = 64'hFFFF;
        w.meters = quot[dtdc_pkg::DEPTH_W-1:0];
        w.code = code_full[dtdc_pkg::CODE_W-1:0];
        w.valid = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic int draw_wait(bit en);
    return en ? int'($urandom_range(0, 19)) : 0;
  endfunction

  task automatic queue_pixel(logic signed [dtdc_pkg::DISP_W-1:0] d, logic f);
    pixel_backlog.push_back('{disp: d, fin: f});
  endtask

  task automatic write_registers(logic [dtdc_pkg::CFG_W-1:0] fb, logic [dtdc_pkg::CFG_W-1:0] mn,
                                 logic [dtdc_pkg::CFG_W-1:0] mx, logic [dtdc_pkg::CFG_W-1:0] sc);
    dtdc_pkg::cfg_idx_e         order [4];
    logic [dtdc_pkg::CFG_W-1:0] vals [4];
    order = '{dtdc_pkg::CFG_FOCAL_BASELINE, dtdc_pkg::CFG_MIN_DEPTH,
              dtdc_pkg::CFG_MAX_DEPTH, dtdc_pkg::CFG_CODE_SCALE};
    vals = '{fb, mn, mx, sc};
    @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (order[i])
        dtdc_pkg::CFG_FOCAL_BASELINE: focal_baseline = vals[i];
        dtdc_pkg::CFG_MIN_DEPTH:      min_depth = vals[i];
        dtdc_pkg::CFG_MAX_DEPTH:      max_depth = vals[i];
        dtdc_pkg::CFG_CODE_SCALE:     code_scale = vals[i][dtdc_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_backlog.size() != 0 || in_valid_i || pending_depths.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        pending_depths.push_back(convert_pixel(disparity_i, disparity_finite_i));
        tx_wait = draw_wait(tx_idle_en);
      end
      // hold a stalled word
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_wait > 0) begin
          in_valid_i <= 1'b0;
          tx_wait--;
        end else if (pixel_backlog.size() != 0) begin
          tx_pixel = pixel_backlog.pop_front();
          disparity_i <= tx_pixel.disp;
          disparity_finite_i <= tx_pixel.fin;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_depths.size() == 0) begin
          $error("depth word with none expected");
          errors++;
        end else begin
          rx_word = pending_depths.pop_front();
          if (depth_m_o !== rx_word.meters) begin
            $error("depth_m: expected %0d, got %0d", rx_word.meters, depth_m_o);
            errors++;
          end
          if (depth_code_o !== rx_word.code) begin
            $error("depth_code: expected %0d, got %0d", rx_word.code, depth_code_o);
            errors++;
          end
          if (depth_valid_o !== rx_word.valid) begin
            $error("depth_valid: expected %0d, got %0d", rx_word.valid, depth_valid_o);
            errors++;
          end
        end
        rx_wait = draw_wait(rx_idle_en);
      end
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [dtdc_pkg::CFG_W-1:0] fb;
    logic [dtdc_pkg::CFG_W-1:0] mn;
    logic [dtdc_pkg::CFG_W-1:0] mx;
    logic [dtdc_pkg::CFG_W-1:0] sc;
    logic signed [dtdc_pkg::DISP_W-1:0] d;
    logic f;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: zero, negative, range edges, not finite
    queue_pixel(17'sd0, 1'b1);
    queue_pixel(-17'sd1, 1'b1);
    queue_pixel(17'h10000, 1'b1);
    queue_pixel(17'sd65535, 1'b1);
    queue_pixel(17'sd1, 1'b1);
    queue_pixel(17'sd32, 1'b1);
    queue_pixel(17'sd16, 1'b1);
    queue_pixel(17'sd16000, 1'b1);
    queue_pixel(17'sd16001, 1'b1);
    queue_pixel(17'sd32, 1'b0);
    wait_drained();

    // quotient overflow and code saturation
    write_registers(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF);
    @(negedge clk_i);
    queue_pixel(17'sd1, 1'b1);
    queue_pixel(17'sd2, 1'b1);
    queue_pixel(17'sd65535, 1'b1);
    wait_drained();

    // zero depth accepted, wide scale write
    write_registers(32'd0, 32'd0, 32'd0, 32'hFFFF_0001);
    @(negedge clk_i);
    queue_pixel(17'sd1, 1'b1);
    queue_pixel(17'sd65535, 1'b1);
    wait_drained();

    // code rounding to zero and half up
    write_registers(32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 32'd1);
    @(negedge clk_i);
    queue_pixel(17'sd65535, 1'b1);
    queue_pixel(17'sd64, 1'b1);
    queue_pixel(17'sd65, 1'b1);
    wait_drained();

    // zero scale
    write_registers(32'h0001_0000, 32'd0, 32'hFFFF_FFFF, 32'hABCD_0000);
    @(negedge clk_i);
    queue_pixel(17'sd32, 1'b1);
    wait_drained();

    // min above max rejects everything
    write_registers(32'h0032_0000, 32'hFFFF_FFFF, 32'd0, 32'd1000);
    @(negedge clk_i);
    queue_pixel(17'sd32, 1'b1);
    queue_pixel(17'sd1, 1'b1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0:       fb = 32'd0;
        1:       fb = 32'hFFFF_FFFF;
        2:       fb = $urandom;
        default: fb = $urandom_range(32'h0001_0000, 32'h0190_0000);
      endcase
      case ($urandom_range(0, 4))
        0:       mn = 32'd0;
        1:       mn = $urandom;
        default: mn = $urandom_range(0, 32'h0001_0000);
      endcase
      case ($urandom_range(0, 4))
        0:       mx = $urandom;
        1:       mx = 32'hFFFF_FFFF;
        default: mx = $urandom_range(32'h0001_0000, 32'h012C_0000);
      endcase
      case ($urandom_range(0, 4))
        0:       sc = 32'd1;
        1:       sc = 32'hFFFF;
        default: sc = $urandom_range(1, 65535);
      endcase
      sc[31:16] = 16'($urandom);
      write_registers(fb, mn, mx, sc);
      @(negedge clk_i);
      tx_idle_en = $urandom_range(0, 2) != 0;
      rx_idle_en = $urandom_range(0, 2) != 0;
      for (int n = 0; n < 235; n++) begin
        f = 1'b1;
        case ($urandom_range(0, 19))
          0, 1:    d = dtdc_pkg::DISP_W'(-int'($urandom_range(1, 65536)));
          2:       d = 17'sd0;
          3, 4: begin
            d = dtdc_pkg::DISP_W'($urandom);
            f = 1'b0;
          end
          default: d = dtdc_pkg::DISP_W'($urandom_range(1, (1 << $urandom_range(1, 16)) - 1));
        endcase
        queue_pixel(d, f);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_depths.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
